// ===== rtl/led_driver_serial_writer_top_assert.svh =====
`ifndef LED_DRIVER_SERIAL_WRITER_TOP_ASSERT_SVH
`define LED_DRIVER_SERIAL_WRITER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define LDSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ldsw assertion failed");

// next-cycle implication, held off during reset
`define LDSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ldsw assertion failed");

`endif

// ===== rtl/ldsw_pkg.sv =====
package ldsw_pkg;

  localparam int unsigned Digits   = 4;
  localparam int unsigned FrameMax = Digits + 1;
  localparam int unsigned NumSegIn = 4;
  localparam int unsigned ByteIdxW = $clog2(FrameMax + 1);
  localparam int unsigned WaitW    = 11;

  localparam logic [7:0] CmdDataFixed = 8'h44;
  localparam logic [7:0] CmdDataAuto  = 8'h40;
  localparam logic [7:0] CmdAddr      = 8'hC0;
  localparam logic [7:0] CmdDispOn    = 8'h8F;
  localparam logic [7:0] CmdDispOff   = 8'h80;
  localparam logic [7:0] TpuReset     = 8'h01;

  localparam logic [2:0] UnitsStart = 3'd2;
  localparam logic [2:0] UnitsBit   = 3'd3;
  localparam logic [2:0] UnitsAck   = 3'd5;

  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_SHOW_ONE  = 2'd1,
    MODE_CLEAR_ONE = 2'd2,
    MODE_SHOW_ALL  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [1:0]  position;
    logic [31:0] segs;       // byte3..byte0, byte0 lowest
    logic        ack_level;
  } in_item_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy_res;
    logic done_res;
    logic rejected;
  } res_t;

  function automatic logic [WaitW-1:0] wait_len(logic [2:0] units, logic [7:0] tpu);
    logic [7:0]       t;
    logic [WaitW-1:0] prod;
    t    = (tpu == 8'd0) ? 8'd1 : tpu;
    prod = WaitW'(units) * WaitW'(t);
    return prod - WaitW'(1);
  endfunction

endpackage

// ===== rtl/ldsw_seq.sv =====
module ldsw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ldsw_pkg::in_item_t  item_i,
  input  logic [7:0]          tpu_i,
  output ldsw_pkg::res_t      res_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_START = 4'd1,
    ST_SHOLD = 4'd2,
    ST_BLOW  = 4'd3,
    ST_BHIGH = 4'd4,
    ST_ADLY  = 4'd5,
    ST_APOLL = 4'd6,
    ST_AHIGH = 4'd7,
    ST_ALOW  = 4'd8,
    ST_STOP  = 4'd9
  } seq_state_e;

  localparam int unsigned Bw = ldsw_pkg::ByteIdxW;
  localparam int unsigned Ww = ldsw_pkg::WaitW;

  seq_state_e       st_q, st_d, adv_st;
  logic [Bw-1:0]    byte_q, byte_d, adv_byte;
  logic [2:0]       bit_q, bit_d, adv_bit;
  logic [7:0]       shift_q, shift_d, adv_shift;
  logic [Ww-1:0]    wait_q, wait_d, adv_wait;
  logic [1:0]       frame_q, frame_d, adv_frame;
  logic             clk_q, clk_d, adv_clk;
  logic             dio_q, dio_d, adv_dio;
  logic             adv_done;
  logic [7:0]       open_q, open_d;
  logic [7:0]       close_q, close_d;
  logic [Bw-1:0]    mid_q, mid_d;
  logic [7:0]       fb_q [ldsw_pkg::FrameMax];
  logic [7:0]       fb_d [ldsw_pkg::FrameMax];
  logic             start_cmd, is_cmd;
  logic [Bw-1:0]    ld_idx, next_idx, flen;
  logic [7:0]       ld_byte;

  assign is_cmd    = item_i.mode != ldsw_pkg::MODE_TICK;
  assign start_cmd = is_cmd && (st_q == ST_IDLE);

  // byte to shift out when a new byte is loaded
  assign next_idx = byte_q + Bw'(1);
  assign ld_idx   = (st_q == ST_ALOW) ? next_idx : '0;
  assign flen     = (frame_q == 2'd1) ? mid_q : Bw'(1);

  always_comb begin
    if (frame_q == 2'd0) begin
      ld_byte = open_q;
    end else if (frame_q == 2'd2) begin
      ld_byte = close_q;
    end else if (ld_idx < Bw'(ldsw_pkg::FrameMax)) begin
      ld_byte = fb_q[ld_idx[$clog2(ldsw_pkg::FrameMax)-1:0]];
    end else begin
      ld_byte = 8'h00;
    end
  end

  // one clock of a running sequence
  always_comb begin
    adv_st    = st_q;
    adv_byte  = byte_q;
    adv_bit   = bit_q;
    adv_shift = shift_q;
    adv_wait  = wait_q;
    adv_frame = frame_q;
    adv_clk   = clk_q;
    adv_dio   = dio_q;
    adv_done  = 1'b0;
    if (st_q == ST_IDLE) begin
      adv_st = ST_IDLE;
    end else if (st_q == ST_APOLL) begin
      if (!item_i.ack_level) begin
        adv_st   = ST_AHIGH;
        adv_clk  = 1'b1;
        adv_wait = ldsw_pkg::wait_len(ldsw_pkg::UnitsStart, tpu_i);
      end
    end else if (wait_q != '0) begin
      adv_wait = wait_q - Ww'(1);
    end else begin
      unique case (st_q)
        ST_START: begin
          adv_st   = ST_SHOLD;
          adv_dio  = 1'b0;
          adv_wait = '0;
        end
        ST_BLOW: begin
          adv_st   = ST_BHIGH;
          adv_clk  = 1'b1;
          adv_wait = ldsw_pkg::wait_len(ldsw_pkg::UnitsBit, tpu_i);
        end
        ST_BHIGH: begin
          if (bit_q == 3'd7) begin
            adv_st   = ST_ADLY;
            adv_clk  = 1'b0;
            adv_wait = ldsw_pkg::wait_len(ldsw_pkg::UnitsAck, tpu_i);
          end else begin
            adv_bit   = bit_q + 3'd1;
            adv_shift = {1'b0, shift_q[7:1]};
            adv_st    = ST_BLOW;
            adv_clk   = 1'b0;
            adv_dio   = shift_q[1];
            adv_wait  = ldsw_pkg::wait_len(ldsw_pkg::UnitsBit, tpu_i);
          end
        end
        ST_ADLY: begin
          adv_st = ST_APOLL;
        end
        ST_AHIGH: begin
          adv_st   = ST_ALOW;
          adv_clk  = 1'b0;
          adv_wait = '0;
        end
        ST_SHOLD, ST_ALOW: begin
          adv_byte = ld_idx;
          if (st_q == ST_SHOLD || next_idx < flen) begin
            adv_shift = ld_byte;
            adv_bit   = 3'd0;
            adv_st    = ST_BLOW;
            adv_clk   = 1'b0;
            adv_dio   = ld_byte[0];
            adv_wait  = ldsw_pkg::wait_len(ldsw_pkg::UnitsBit, tpu_i);
          end else begin
            adv_st   = ST_STOP;
            adv_clk  = 1'b1;
            adv_dio  = 1'b0;
            adv_wait = ldsw_pkg::wait_len(ldsw_pkg::UnitsStart, tpu_i);
          end
        end
        ST_STOP: begin
          adv_dio  = 1'b1;
          adv_byte = '0;
          if (frame_q != 2'd2) begin
            adv_frame = frame_q + 2'd1;
            adv_st    = ST_START;
            adv_clk   = 1'b1;
            adv_wait  = ldsw_pkg::wait_len(ldsw_pkg::UnitsStart, tpu_i);
          end else begin
            adv_st    = ST_IDLE;
            adv_frame = 2'd0;
            adv_wait  = '0;
            adv_done  = 1'b1;
          end
        end
        default: begin
          adv_st = ST_IDLE;
        end
      endcase
    end
  end

  // frame contents of a new command
  always_comb begin
    for (int unsigned i = 0; i < ldsw_pkg::FrameMax; i++) begin
      fb_d[i] = 8'h00;
      if (item_i.mode == ldsw_pkg::MODE_SHOW_ALL) begin
        if (i == 0) begin
          fb_d[i] = ldsw_pkg::CmdAddr;
        end else if (i <= ldsw_pkg::NumSegIn) begin
          fb_d[i] = 8'(item_i.segs >> (8 * (i - 1)));
        end
      end else if (i == 0) begin
        fb_d[i] = ldsw_pkg::CmdAddr + {6'd0, item_i.position};
      end else if (i == 1 && item_i.mode == ldsw_pkg::MODE_SHOW_ONE) begin
        fb_d[i] = item_i.segs[7:0];
      end
    end
  end

  always_comb begin
    st_d    = st_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    frame_d = frame_q;
    clk_d   = clk_q;
    dio_d   = dio_q;
    open_d  = open_q;
    close_d = close_q;
    mid_d   = mid_q;
    res_o   = '0;
    if (start_cmd) begin
      if (item_i.mode == ldsw_pkg::MODE_SHOW_ALL) begin
        open_d  = ldsw_pkg::CmdDataAuto;
        close_d = ldsw_pkg::CmdDispOn;
        mid_d   = Bw'(ldsw_pkg::FrameMax);
      end else if (item_i.mode == ldsw_pkg::MODE_SHOW_ONE) begin
        open_d  = ldsw_pkg::CmdDataFixed;
        close_d = ldsw_pkg::CmdDispOn;
        mid_d   = Bw'(2);
      end else begin
        open_d  = ldsw_pkg::CmdDataAuto;
        close_d = ldsw_pkg::CmdDispOff;
        mid_d   = Bw'(2);
      end
      frame_d = 2'd0;
      byte_d  = '0;
      bit_d   = 3'd0;
      st_d    = ST_START;
      clk_d   = 1'b1;
      dio_d   = 1'b1;
      wait_d  = ldsw_pkg::wait_len(ldsw_pkg::UnitsStart, tpu_i);
    end else begin
      st_d    = adv_st;
      byte_d  = adv_byte;
      bit_d   = adv_bit;
      shift_d = adv_shift;
      wait_d  = adv_wait;
      frame_d = adv_frame;
      clk_d   = adv_clk;
      dio_d   = adv_dio;
      res_o.done_res = adv_done;
    end
    res_o.rejected  = is_cmd && !start_cmd;
    res_o.clk_level = clk_d;
    res_o.dio_level = dio_d;
    res_o.busy_res  = st_d != ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      byte_q  <= '0;
      bit_q   <= 3'd0;
      shift_q <= 8'h00;
      wait_q  <= '0;
      frame_q <= 2'd0;
      clk_q   <= 1'b1;
      dio_q   <= 1'b1;
      open_q  <= ldsw_pkg::CmdDataAuto;
      close_q <= ldsw_pkg::CmdDispOff;
      mid_q   <= Bw'(1);
    end else if (step_i) begin
      st_q    <= st_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      frame_q <= frame_d;
      clk_q   <= clk_d;
      dio_q   <= dio_d;
      open_q  <= open_d;
      close_q <= close_d;
      mid_q   <= mid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && start_cmd) begin
      fb_q <= fb_d;
    end
  end

endmodule

// ===== rtl/led_driver_serial_writer_top.sv =====
// Two-wire LED display driver command writer. Every input item is one clock of line
// timing and yields exactly one output item with the clock and data line levels; an
// item with tuser 1, 2 or 3 starts show one digit, clear one digit or show all digits
// when idle and is flagged rejected when a sequence is running. Line waits are 2, 3
// and 5 units of cfg_data_i items (0 acts as 1). The block takes one item per clock
// unless the output stalls; the result is registered and shown in the cycle after
// acceptance; a new item is taken in the same cycle as the waiting result.
// Write the unit length only while no item is in flight; a running sequence uses the
// new length from its next wait on.
`include "led_driver_serial_writer_top_assert.svh"

module led_driver_serial_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,    // ticks_per_unit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position, byte0, byte1, byte2, byte3, ack_level
  input  logic [1:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // clk_level, dio_level, busy_res, rejected
  output logic        m_axis_tlast   // done_res
);

  logic               step;
  logic [7:0]         tpu_q;
  ldsw_pkg::in_item_t item;
  ldsw_pkg::res_t     res, res_q;
  logic               valid_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  assign item.mode      = ldsw_pkg::mode_e'(s_axis_tuser);
  assign item.position  = s_axis_tdata[1:0];
  assign item.segs      = s_axis_tdata[33:2];
  assign item.ack_level = s_axis_tdata[34];

  ldsw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .tpu_i  (tpu_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q   <= ldsw_pkg::TpuReset;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tpu_q <= cfg_data_i;
      end
      if (step) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {4'd0, res_q.rejected, res_q.busy_res, res_q.dio_level,
                          res_q.clk_level};
  assign m_axis_tlast  = res_q.done_res;

  `LDSW_ASSERT_NEXT(a_item_gives_result, step, m_axis_tvalid)
  `LDSW_ASSERT_NOW(a_done_ends_busy, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[2])
  `LDSW_ASSERT_NOW(a_idle_lines_high, m_axis_tvalid && !m_axis_tdata[2],
                   m_axis_tdata[0] && m_axis_tdata[1])

endmodule
